>>> design/pjw_key_hash_bucket_index_assert.svh
// Assertion macros for the checker file of the key hash block.
`ifndef PJW_KEY_HASH_BUCKET_INDEX_ASSERT_SVH
`define PJW_KEY_HASH_BUCKET_INDEX_ASSERT_SVH

// Same-cycle implication, inactive while reset is asserted.
`define PJW_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, inactive while reset is asserted.
`define PJW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define PJW_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pjw_pkg.sv
`default_nettype none

package pjw_pkg;

    localparam int HASH_W   = 28;
    localparam int BUCKET_W = 32;
    localparam int BYTE_W   = 8;
    localparam int STEP_W   = 4;

    // Configuration register indexes.
    localparam logic [0:0] REG_BUCKET_COUNT = 1'd0;
    localparam logic [0:0] REG_SIGNED_BYTES = 1'd1;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    // Job handed from the byte front end to the remainder unit.
    typedef struct packed {
        logic                start;
        logic [HASH_W-1:0]   dividend;
        logic [BUCKET_W-1:0] divisor;
    } div_req_t;

    // One PJW step: shift by a nibble, add the extended byte, fold the top nibble
    // into bits 7..4 and clear it. The running hash never holds bits 31..28.
    function automatic logic [HASH_W-1:0] pjw_fold(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b,
        input logic              sgn
    );
        logic [31:0] ext;
        logic [31:0] sum;
        logic [3:0]  top;
        ext = {{(32-BYTE_W){sgn & b[BYTE_W-1]}}, b};
        sum = {h, {STEP_W{1'b0}}} + ext;
        top = sum[31:28];
        return {sum[27:8], sum[7:4] ^ top, sum[3:0]};
    endfunction

endpackage

`default_nettype wire

>>> design/pjw_key_hash_bucket_index.sv
// PJW key hash with bucket index.
// Key bytes arrive on the s_ stream, one byte per beat, with s_tlast on the final
// byte of each key. Bytes that are not final are folded into the running hash
// at one beat per cycle while the remainder unit is idle. The final byte starts a
// bit-serial remainder unit that reduces the 28-bit hash modulo bucket_count,
// one hash bit per cycle. s_tready stays low while that unit works, so no byte of
// a new key is taken until the last result has moved to the output register, after
// the 28 remainder steps and a handoff state, DONE, that waits for room there.
// The m_ beat carries the raw hash and the bucket index. It sits in an output
// register, so while the receiver stalls the front end keeps taking the next
// key; only the handoff of the following result waits for m_tready.
// A bucket_count of zero gives the hash itself as the index.
// Registers are written through cfg_wr_* by the user only while no key is in flight;
// the block does not enforce it. Reset (aresetn low, synchronous) clears the
// running hash and the result stream, and sets bucket_count to 1 and signed_bytes to 1.
`default_nettype none

module pjw_key_hash_bucket_index
    import pjw_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] key_byte
    input  wire logic                s_tlast,   // last_byte
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [63:0]              m_tdata,   // [27:0] hash_value, [59:28] bucket_index
    input  wire logic                cfg_wr_en,
    input  wire logic [0:0]          cfg_wr_index,
    input  wire logic [31:0]         cfg_wr_data
);

    logic [BUCKET_W-1:0] bucket_count_reg, bucket_count_next;
    logic                signed_bytes_reg, signed_bytes_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [HASH_W-1:0]   folded;
    logic                s_beat;
    logic                div_ready;
    div_req_t            div_req;
    logic [HASH_W-1:0]   out_hash;
    logic [BUCKET_W-1:0] out_index;

    always_comb begin
        bucket_count_next = bucket_count_reg;
        signed_bytes_next = signed_bytes_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_BUCKET_COUNT: bucket_count_next = cfg_wr_data;
                REG_SIGNED_BYTES: signed_bytes_next = cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    assign s_tready = div_ready;
    assign s_beat   = s_tvalid && s_tready;
    assign folded   = pjw_fold(hash_reg, s_tdata, signed_bytes_reg);

    always_comb begin
        hash_next = hash_reg;
        if (s_beat) begin
            hash_next = s_tlast ? '0 : folded;
        end
    end

    assign div_req.start    = s_beat && s_tlast;
    assign div_req.dividend = folded;
    assign div_req.divisor  = bucket_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= BUCKET_W'(1);
            signed_bytes_reg <= 1'b1;
            hash_reg         <= '0;
        end else begin
            bucket_count_reg <= bucket_count_next;
            signed_bytes_reg <= signed_bytes_next;
            hash_reg         <= hash_next;
        end
    end

    pjw_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (div_req),
        .ready     (div_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hash  (out_hash),
        .out_index (out_index)
    );

    assign m_tdata = {4'b0000, out_index, out_hash};

endmodule

`default_nettype wire

>>> design/pjw_div.sv
`default_nettype none

module pjw_div
    import pjw_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire div_req_t            req,
    output logic                     ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [HASH_W-1:0]        out_hash,
    output logic [BUCKET_W-1:0]      out_index
);

    localparam int CNT_W = $clog2(HASH_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

    div_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [HASH_W-1:0]   dvd_reg, dvd_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [BUCKET_W-1:0] dsr_reg, dsr_next;
    logic [BUCKET_W-1:0] rem_reg, rem_next;
    logic                out_valid_reg, out_valid_next;
    logic [HASH_W-1:0]   out_hash_reg, out_hash_next;
    logic [BUCKET_W-1:0] out_index_reg, out_index_next;

    logic                step_en;
    logic                load_out;
    logic [BUCKET_W:0]   trial;
    logic [BUCKET_W:0]   diff;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: begin
                if (req.start) begin
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (cnt_reg == CNT_LAST) begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    state_next = DIV_IDLE;
                end
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    always_comb begin
        ready    = 1'b0;
        step_en  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            DIV_IDLE: ready    = 1'b1;
            DIV_RUN:  step_en  = 1'b1;
            DIV_DONE: load_out = !out_valid_reg || out_ready;
            default: ready    = 1'b0;
        endcase
    end

    // Restoring division, one dividend bit per cycle. A zero divisor never
    // subtracts anything, so the remainder ends equal to the dividend.
    assign trial = {rem_reg, dvd_reg[HASH_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        hash_next = hash_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (ready && req.start) begin
            cnt_next  = '0;
            dvd_next  = req.dividend;
            hash_next = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end else if (step_en) begin
            cnt_next = cnt_reg + CNT_W'(1);
            dvd_next = {dvd_reg[HASH_W-2:0], 1'b0};
            if (!diff[BUCKET_W]) begin
                rem_next = diff[BUCKET_W-1:0];
            end else begin
                rem_next = trial[BUCKET_W-1:0];
            end
        end
    end

    always_comb begin
        out_hash_next  = out_hash_reg;
        out_index_next = out_index_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load_out) begin
            out_hash_next  = hash_reg;
            out_index_next = rem_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= DIV_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg       <= dvd_next;
        hash_reg      <= hash_next;
        dsr_reg       <= dsr_next;
        rem_reg       <= rem_next;
        out_hash_reg  <= out_hash_next;
        out_index_reg <= out_index_next;
    end

    assign out_valid = out_valid_reg;
    assign out_hash  = out_hash_reg;
    assign out_index = out_index_reg;

endmodule

`default_nettype wire

>>> design/pjw_chk.sv
`default_nettype none

`include "pjw_key_hash_bucket_index_assert.svh"

module pjw_chk
    import pjw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_wr_index,
    input  wire logic [31:0] cfg_wr_data
);

    // Shadow of the bucket count, rebuilt from the write port.
    logic [31:0] bc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bc_reg <= 32'd1;
        end else if (cfg_wr_en && cfg_wr_index == REG_BUCKET_COUNT) begin
            bc_reg <= cfg_wr_data;
        end
    end

    `PJW_ASSERT_NEXT_ALWAYS(a_reset_quiet, aclk, !aresetn, !m_tvalid,
        "result beat valid right after reset")

    `PJW_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "stalled result beat changed")

    `PJW_ASSERT_SAME(a_index_range, aclk, aresetn, m_tvalid && bc_reg != 32'd0,
        m_tdata[59:28] < bc_reg, "bucket index not below bucket count")

    `PJW_ASSERT_SAME(a_index_passthru, aclk, aresetn, m_tvalid && bc_reg == 32'd0,
        m_tdata[59:28] == 32'(m_tdata[27:0]), "zero bucket count must pass hash")

    `PJW_ASSERT_NEXT(a_busy_after_last, aclk, aresetn, s_tvalid && s_tready && s_tlast,
        !s_tready, "input ready while the remainder unit is busy")

endmodule

bind pjw_key_hash_bucket_index pjw_chk u_pjw_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data)
);

`default_nettype wire

>>> test/tb_pjw_key_hash_bucket_index.sv
`timescale 1ns / 100ps

module tb_pjw_key_hash_bucket_index
    import pjw_pkg::*;
();

    localparam int CYCLE_LIMIT     = 500000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASES          = 12;
    localparam int BYTES_PER_PHASE = 125;

    typedef struct packed {
        logic [27:0] hash;
        logic [31:0] index;
    } key_result_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_CFG
    } row_kind_t;

    // For a byte row arg_a is the key byte and arg_b the last flag; for a register
    // row arg_a is the register index and arg_b the value written.
    typedef struct {
        row_kind_t   kind;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
        bit          typed;
        logic [27:0] hash;
        logic [31:0] index;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] key_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // [27:0] hash_value, [59:28] bucket_index
    logic        cfg_wr_en;
    logic [0:0]  cfg_wr_index;
    logic [31:0] cfg_wr_data;

    logic [31:0] bucket_cnt;
    logic        sign_mode;
    logic [31:0] run_hash;
    key_result_t hash_due_q[$];
    key_result_t rx_due;
    stim_row_t   stim_rows[$];
    int          fails;
    int          cycles;
    bit          tx_calm;
    bit          rx_calm;

    pjw_key_hash_bucket_index dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[pjw_key_hash_bucket_index] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] pjw_absorb(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] sum;
        logic [31:0] top;
        sum = (h << 4) + ((sign_mode && b[7]) ? {24'hffffff, b} : {24'h000000, b});
        top = sum & 32'hf000_0000;
        // The top nibble is folded into bits 7..4 and then cleared.
        if (top != 32'd0)
            sum = sum ^ (top >> 24) ^ top;
        return sum;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input logic [27:0] t_hash, input logic [31:0] t_index);
        int          gap;
        logic [31:0] h;
        key_result_t r;
        gap = tx_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        h = pjw_absorb(run_hash, b);
        if (!last) begin
            run_hash = h;
        end else begin
            r.hash  = h[27:0];
            r.index = (bucket_cnt != 32'd0) ? h % bucket_cnt : h;
            if (typed) begin
                r.hash  = t_hash;
                r.index = t_index;
            end
            hash_due_q.push_back(r);
            run_hash = 32'd0;
        end
    endtask

    // Holds the sender off until every pending key has produced its beat and the
    // remainder unit has had time to go quiet.
    task automatic wait_idle;
        s_tvalid <= 1'b0;
        while (hash_due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [0:0] which, input logic [31:0] value);
        wait_idle();
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= which;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (which == REG_BUCKET_COUNT)
            bucket_cnt = value;
        else
            sign_mode = value[0];
    endtask

    task automatic add_row(input row_kind_t kind, input logic [31:0] a, input logic [31:0] b,
                           input bit typed, input logic [27:0] h, input logic [31:0] i);
        stim_row_t row;
        row.kind  = kind;
        row.arg_a = a;
        row.arg_b = b;
        row.typed = typed;
        row.hash  = h;
        row.index = i;
        stim_rows.push_back(row);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (hash_due_q.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result beat: hash %h index %h",
                             m_tdata[27:0], m_tdata[59:28]);
            end else begin
                rx_due = hash_due_q.pop_front();
                if (m_tdata[27:0] !== rx_due.hash || m_tdata[59:28] !== rx_due.index) begin
                    fails++;
                    if (fails <= 10)
                        $display("mismatch: hash exp %h got %h, index exp %h got %h",
                                 rx_due.hash, m_tdata[27:0], rx_due.index, m_tdata[59:28]);
                end
            end
        end
    end

    initial begin
        int stall;
        int beats;
        m_tready = 1'b0;
        rx_calm  = 1'b0;
        beats    = 0;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_calm ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            beats++;
            if (beats % 16 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        int          ph;
        int          sent;
        int          len;
        int          k;
        logic [7:0]  b;
        logic [31:0] value;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tlast      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_BUCKET_COUNT;
        cfg_wr_data  = 32'd0;
        bucket_cnt   = 32'd1;
        sign_mode    = 1'b1;
        run_hash     = 32'd0;
        fails        = 0;
        cycles       = 0;
        tx_calm      = 1'b0;

        // Reset state: one bucket, sign-extended bytes.
        add_row(ROW_BYTE, 32'h00, 32'd1, 1'b1, 28'h0000000, 32'h0);
        add_row(ROW_BYTE, 32'hff, 32'd1, 1'b1, 28'hfffff0f, 32'h0);
        add_row(ROW_BYTE, 32'h80, 32'd1, 1'b1, 28'hfffff70, 32'h0);
        add_row(ROW_BYTE, 32'h7f, 32'd1, 1'b1, 28'h000007f, 32'h0);
        // Seven bytes push the first one into the top nibble.
        for (k = 0; k < 7; k++)
            add_row(ROW_BYTE, 32'h61 + k, 32'(k == 6), 1'b0, 28'h0, 32'h0);
        // A zero bucket count passes the hash through as the index.
        add_row(ROW_CFG, 32'(REG_BUCKET_COUNT), 32'h0, 1'b0, 28'h0, 32'h0);
        add_row(ROW_BYTE, 32'hff, 32'd1, 1'b1, 28'hfffff0f, 32'h0fffff0f);
        add_row(ROW_CFG, 32'(REG_BUCKET_COUNT), 32'hffffffff, 1'b0, 28'h0, 32'h0);
        add_row(ROW_BYTE, 32'h80, 32'd1, 1'b1, 28'hfffff70, 32'h0fffff70);
        add_row(ROW_CFG, 32'(REG_SIGNED_BYTES), 32'h0, 1'b0, 28'h0, 32'h0);
        add_row(ROW_BYTE, 32'hff, 32'd1, 1'b1, 28'h00000ff, 32'h000000ff);
        add_row(ROW_BYTE, 32'h80, 32'd1, 1'b1, 28'h0000080, 32'h00000080);
        for (k = 0; k < 7; k++)
            add_row(ROW_BYTE, 32'hff, 32'(k == 6), 1'b0, 28'h0, 32'h0);
        add_row(ROW_CFG, 32'(REG_BUCKET_COUNT), 32'd7, 1'b0, 28'h0, 32'h0);
        add_row(ROW_BYTE, 32'h0a, 32'd1, 1'b1, 28'h000000a, 32'd3);
        add_row(ROW_BYTE, 32'h12, 32'd0, 1'b0, 28'h0, 32'h0);
        add_row(ROW_BYTE, 32'h34, 32'd0, 1'b0, 28'h0, 32'h0);
        add_row(ROW_BYTE, 32'h56, 32'd1, 1'b0, 28'h0, 32'h0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG)
                cfg_write(stim_rows[i].arg_a[0], stim_rows[i].arg_b);
            else
                send_byte(stim_rows[i].arg_a[7:0], stim_rows[i].arg_b[0],
                          stim_rows[i].typed, stim_rows[i].hash, stim_rows[i].index);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: value = 32'd0;
                1: value = 32'hffffffff;
                2: value = 32'd1;
                default: begin
                    case ($urandom_range(0, 5))
                        0: value = 32'd0;
                        1: value = 32'hffffffff;
                        2: value = $urandom_range(2, 16);
                        3: value = 32'h1 << $urandom_range(1, 31);
                        4: value = $urandom_range(17, 32'h0fffffff);
                        default: value = $urandom;
                    endcase
                end
            endcase
            cfg_write(REG_BUCKET_COUNT, value);
            // Upper bits of the mode write are junk that the block must ignore.
            value = $urandom;
            value[0] = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
            cfg_write(REG_SIGNED_BYTES, value);

            tx_calm = (ph % 4 == 3);
            sent = 0;
            while (sent < BYTES_PER_PHASE) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                  : $urandom_range(1, 10);
                for (k = 0; k < len; k++) begin
                    b = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 7) == 0) begin
                        case ($urandom_range(0, 3))
                            0: b = 8'h00;
                            1: b = 8'h7f;
                            2: b = 8'h80;
                            default: b = 8'hff;
                        endcase
                    end
                    send_byte(b, (k == len - 1), 1'b0, 28'h0, 32'h0);
                    sent++;
                end
                if ($urandom_range(0, 39) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        if (fails == 0)
            $display("[pjw_key_hash_bucket_index] OK");
        else
            $display("[pjw_key_hash_bucket_index] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/pjw_pkg.sv
design/pjw_div.sv
design/pjw_key_hash_bucket_index.sv
design/pjw_chk.sv
test/tb_pjw_key_hash_bucket_index.sv
